FILE: sv/fpts_pkg.sv
// ----------------------------------------------------------------------------
// fpts_pkg: shared types and codes for the feedback priority task scheduler
// Event codes, task status codes and configuration register indexes.
// ----------------------------------------------------------------------------
package fpts_pkg;

  // Table depth, tied to the 4-bit task id
  localparam int MAX_TASKS = 16;

  typedef enum logic [2:0] {
    EV_TIMEOUT  = 3'd0,
    EV_STARTED  = 3'd1,
    EV_CONTINUE = 3'd2,
    EV_FINISHED = 3'd3,
    EV_DEMOTED  = 3'd4,
    EV_IDLE     = 3'd5,
    EV_DONE     = 3'd6
  } event_e;

  typedef enum logic [1:0] {
    ST_WAITING    = 2'd0,
    ST_READY      = 2'd1,
    ST_TERMINATED = 2'd2
  } status_e;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [0:0] REG_TIMEOUT = 1'b0;
  localparam logic [0:0] REG_FLOOR   = 1'b1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd20;
  localparam logic [3:0]  FLOOR_RESET   = 4'd3;
  localparam logic [3:0]  PRIO_MAX      = 4'd15;

endpackage

FILE: sv/feedback_priority_task_scheduler.sv
// ----------------------------------------------------------------------------
// feedback_priority_task_scheduler
// Task table with timeout, admission and lowest-priority selection per tick.
// ----------------------------------------------------------------------------
// A load item passes through the post state before the next accept. A tick
// item makes two passes over the loaded tasks (none with an empty table): one
// table entry per cycle in the timeout/admission pass, one per cycle in the
// selection pass through the shared compare unit, then run and report.
// Results appear at most one per cycle on result_valid_o and cannot be stalled.
// Reset clears counters and control; table entries are undefined until loaded.
module feedback_priority_task_scheduler
  import fpts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cmd_i,
  input  logic [15:0] arrival_time_i,
  input  logic [3:0]  priority_req_i,
  input  logic [9:0]  burst_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [2:0]  event_res_o,
  output logic [3:0]  task_id_o,
  output logic [3:0]  task_priority_o,
  output logic [9:0]  remaining_o,
  output logic [15:0] time_now_o,
  output logic        last_o
);

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_TASKS);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SEL, S_RUN, S_POST
  } state_e;

  // Task table
  logic [15:0] arr_m [MAX_TASKS];
  logic [3:0]  pri_m [MAX_TASKS];
  logic [9:0]  rem_m [MAX_TASKS];
  logic [15:0] act_m [MAX_TASKS];
  logic [15:0] qen_m [MAX_TASKS];
  logic [1:0]  sts_m [MAX_TASKS];

  state_e      state_q;
  logic [CW-1:0] cnt_q;
  logic [IW-1:0] idx_q;
  logic [15:0] tick_q;
  logic [3:0]  prev_q;
  logic        prev_v_q;
  logic [15:0] tmo_q;
  logic [3:0]  floor_q;
  logic        active_q;
  logic        found_q;
  logic [IW-1:0] sel_q;
  logic [3:0]  sel_pri_q;
  logic [15:0] sel_qen_q;
  logic [9:0]  sel_rem_q;
  logic        pend_q;
  logic [2:0]  pend_ev_q;
  logic [3:0]  pend_pri_q;
  logic [9:0]  pend_rem_q;

  logic [IW-1:0] last_idx;
  logic [15:0] idle_t;
  logic        better;
  logic [9:0]  rem_dec;
  logic [15:0] tick_inc;

  assign last_idx = IW'(cnt_q - CW'(1));
  assign idle_t   = tick_q - act_m[idx_q];
  assign tick_inc = tick_q + 16'd1;
  assign rem_dec  = (sel_rem_q != 10'd0) ? sel_rem_q - 10'd1 : 10'd0;

  // Shared compare unit for selection
  always_comb begin
    better = 1'b0;
    if (!found_q) begin
      better = 1'b1;
    end else if (pri_m[idx_q] < sel_pri_q) begin
      better = 1'b1;
    end else if (pri_m[idx_q] == sel_pri_q && pri_m[idx_q] >= floor_q &&
                 qen_m[idx_q] < sel_qen_q) begin
      better = 1'b1;
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // Sequencer, registered results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      cnt_q          <= '0;
      idx_q          <= '0;
      tick_q         <= '0;
      prev_q         <= '0;
      prev_v_q       <= 1'b0;
      tmo_q          <= TIMEOUT_RESET;
      floor_q        <= FLOOR_RESET;
      active_q       <= 1'b0;
      found_q        <= 1'b0;
      pend_q         <= 1'b0;
      result_valid_o <= 1'b0;
      last_o         <= 1'b0;
    end else begin
      result_valid_o <= 1'b0;
      last_o         <= 1'b0;
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_TIMEOUT) tmo_q <= cfg_data_i;
        else floor_q <= cfg_data_i[3:0];
      end
      case (state_q)
        S_IDLE: begin
          if (start) begin
            if (cmd_i == CMD_LOAD) begin
              if (cnt_q < FULL) begin
                arr_m[IW'(cnt_q)] <= arrival_time_i;
                pri_m[IW'(cnt_q)] <= priority_req_i;
                rem_m[IW'(cnt_q)] <= burst_i;
                act_m[IW'(cnt_q)] <= arrival_time_i;
                qen_m[IW'(cnt_q)] <= arrival_time_i;
                sts_m[IW'(cnt_q)] <= ST_WAITING;
                cnt_q <= cnt_q + CW'(1);
              end
              state_q <= S_POST;
            end else begin
              idx_q    <= '0;
              active_q <= 1'b0;
              found_q  <= 1'b0;
              state_q  <= (cnt_q == '0) ? S_RUN : S_SCAN;
            end
          end
        end
        // Timeout then admission, one entry per cycle
        S_SCAN: begin
          if (sts_m[idx_q] != ST_TERMINATED) begin
            active_q <= 1'b1;
            if (sts_m[idx_q] != ST_WAITING) begin
              if (idle_t >= tmo_q) begin
                sts_m[idx_q]    <= ST_TERMINATED;
                result_valid_o  <= 1'b1;
                event_res_o     <= EV_TIMEOUT;
                task_id_o       <= 4'(idx_q);
                task_priority_o <= pri_m[idx_q];
                remaining_o     <= rem_m[idx_q];
                time_now_o      <= tick_q;
              end
            end else if (arr_m[idx_q] <= tick_q) begin
              sts_m[idx_q] <= ST_READY;
            end
          end
          if (idx_q == last_idx) begin
            idx_q   <= '0;
            state_q <= S_SEL;
          end else begin
            idx_q <= idx_q + IW'(1);
          end
        end
        // Selection pass
        S_SEL: begin
          if (sts_m[idx_q] == ST_READY && better) begin
            found_q   <= 1'b1;
            sel_q     <= idx_q;
            sel_pri_q <= pri_m[idx_q];
            sel_qen_q <= qen_m[idx_q];
            sel_rem_q <= rem_m[idx_q];
          end
          if (idx_q == last_idx) state_q <= S_RUN;
          else idx_q <= idx_q + IW'(1);
        end
        // Report and run the picked task, or report idle or done
        S_RUN: begin
          result_valid_o <= 1'b1;
          time_now_o     <= tick_q;
          state_q        <= S_POST;
          if (!active_q) begin
            event_res_o <= EV_DONE; task_id_o <= '0; task_priority_o <= '0;
            remaining_o <= '0; last_o <= 1'b1;
          end else if (!found_q) begin
            event_res_o <= EV_IDLE; task_id_o <= '0; task_priority_o <= '0;
            remaining_o <= '0; last_o <= 1'b1;
            tick_q <= tick_inc; prev_v_q <= 1'b0; prev_q <= '0;
          end else begin
            event_res_o     <= (prev_v_q && prev_q == 4'(sel_q)) ? EV_CONTINUE
                                                                 : EV_STARTED;
            task_id_o       <= 4'(sel_q);
            task_priority_o <= sel_pri_q;
            remaining_o     <= sel_rem_q;
            tick_q          <= tick_inc;
            rem_m[sel_q]    <= rem_dec;
            act_m[sel_q]    <= tick_inc;
            pend_rem_q      <= rem_dec;
            if (rem_dec == 10'd0) begin
              sts_m[sel_q] <= ST_TERMINATED;
              prev_v_q <= 1'b0; prev_q <= '0;
              pend_q <= 1'b1;
              pend_ev_q <= EV_FINISHED; pend_pri_q <= sel_pri_q;
            end else begin
              prev_v_q <= 1'b1; prev_q <= 4'(sel_q);
              qen_m[sel_q] <= tick_inc;
              if (sel_pri_q == 4'd0) begin
                last_o <= 1'b1;
              end else begin
                pend_q     <= 1'b1;
                pend_ev_q  <= EV_DEMOTED;
                pend_pri_q <= (sel_pri_q < PRIO_MAX) ? sel_pri_q + 4'd1 : PRIO_MAX;
                pri_m[sel_q] <= (sel_pri_q < PRIO_MAX) ? sel_pri_q + 4'd1 : PRIO_MAX;
              end
            end
          end
        end
        // Second result of a run if one is pending, or end of a load
        S_POST: begin
          if (pend_q) begin
            result_valid_o  <= 1'b1;
            event_res_o     <= pend_ev_q;
            task_priority_o <= pend_pri_q;
            remaining_o     <= pend_rem_q;
            time_now_o      <= tick_q;
            last_o          <= 1'b1;
          end
          pend_q  <= 1'b0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> result_valid_o) else $error("last without result");
  a_busy_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i == CMD_TICK) |=> busy) else $error("tick not taken");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FULL) else $error("task count overflow");
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_q) else $error("pending result lost");

endmodule

FILE: verif/tb_feedback_priority_task_scheduler.sv
// ----------------------------------------------------------------------------
// tb_feedback_priority_task_scheduler: self-checking testbench
// Sends load and tick items to the scheduler, predicts each event it reports
// with an internal scheduler model and compares every result field by field.
// ----------------------------------------------------------------------------
module tb_feedback_priority_task_scheduler;
  import fpts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NTASK = MAX_TASKS;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [2:0]  ev;
    logic [3:0]  id;
    logic [3:0]  prio;
    logic [9:0]  rem;
    logic [15:0] tnow;
    logic        last;
  } sched_event_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        cmd_i = CMD_LOAD;
  logic [15:0] arrival_time_i = '0;
  logic [3:0]  priority_req_i = '0;
  logic [9:0]  burst_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i = REG_TIMEOUT;
  logic [15:0] cfg_data_i = '0;
  logic        result_valid_o;
  logic [2:0]  event_res_o;
  logic [3:0]  task_id_o;
  logic [3:0]  task_priority_o;
  logic [9:0]  remaining_o;
  logic [15:0] time_now_o;
  logic        last_o;

  feedback_priority_task_scheduler u_top (.*);

  // scheduler shadow state
  logic [15:0] m_arrival [NTASK];
  logic [3:0]  m_prio    [NTASK];
  logic [9:0]  m_rem     [NTASK];
  logic [15:0] m_lastact [NTASK];
  logic [15:0] m_qentry  [NTASK];
  status_e     m_status  [NTASK];
  int          m_loaded;
  logic [15:0] m_tick;
  logic [3:0]  m_prev;
  logic        m_prev_valid;
  logic [15:0] m_timeout;
  logic [3:0]  m_floor;

  sched_event_t expected_events[$];
  int  errors = 0;
  int  cycles = 0;
  int  send_gap_pct = 0;

  initial forever #5 clk_i = ~clk_i;

  // hard stop on hang
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout at %0t", $time);
      $display("Test completed with failures");
      $finish;
    end
  end

  // compare each reported event with the oldest prediction
  always @(posedge clk_i) begin
    sched_event_t got, exp_ev;
    if (rst_ni && result_valid_o) begin
      got = '{event_res_o, task_id_o, task_priority_o, remaining_o, time_now_o, last_o};
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected event expected=none actual=%h", $time, got);
        errors++;
      end else begin
        exp_ev = expected_events.pop_front();
        if (got !== exp_ev) begin
          $display("%0t: mismatch expected ev=%0d id=%0d pri=%0d rem=%0d t=%0d last=%0b",
                   $time, exp_ev.ev, exp_ev.id, exp_ev.prio, exp_ev.rem, exp_ev.tnow,
                   exp_ev.last);
          $display("%0t:          actual   ev=%0d id=%0d pri=%0d rem=%0d t=%0d last=%0b",
                   $time, got.ev, got.id, got.prio, got.rem, got.tnow, got.last);
          errors++;
        end
      end
    end
  end

  function automatic void push_event(event_e ev, int id, logic [3:0] pr, logic [9:0] rm);
    sched_event_t e;
    e = '{ev, id[3:0], pr, rm, m_tick, 1'b0};
    expected_events.push_back(e);
  endfunction

  function automatic void mark_last();
    sched_event_t e;
    e = expected_events[$];
    e.last = 1'b1;
    expected_events[$] = e;
  endfunction

  // predict the events of one item
  function automatic void schedule_item(logic c, logic [15:0] arr, logic [3:0] pr,
                                        logic [9:0] bu);
    int active, sel;
    bit found, better;
    if (c == CMD_LOAD) begin
      if (m_loaded < NTASK) begin
        m_arrival[m_loaded] = arr;
        m_prio[m_loaded] = pr;
        m_rem[m_loaded] = bu;
        m_lastact[m_loaded] = arr;
        m_qentry[m_loaded] = arr;
        m_status[m_loaded] = ST_WAITING;
        m_loaded++;
      end
      return;
    end
    active = 0;
    for (int i = 0; i < m_loaded; i++) begin
      if (m_status[i] == ST_TERMINATED) continue;
      active++;
      if (m_status[i] != ST_WAITING && 16'(m_tick - m_lastact[i]) >= m_timeout) begin
        push_event(EV_TIMEOUT, i, m_prio[i], m_rem[i]);
        m_status[i] = ST_TERMINATED;
      end
    end
    if (active == 0) begin
      push_event(EV_DONE, 0, 0, 0);
      mark_last();
      return;
    end
    for (int i = 0; i < m_loaded; i++)
      if (m_status[i] == ST_WAITING && m_arrival[i] <= m_tick) m_status[i] = ST_READY;
    found = 0;
    sel = 0;
    for (int i = 0; i < m_loaded; i++) begin
      if (m_status[i] != ST_READY) continue;
      better = !found || m_prio[i] < m_prio[sel] ||
               (m_prio[i] == m_prio[sel] && m_prio[i] >= m_floor &&
                m_qentry[i] < m_qentry[sel]);
      if (better) begin
        found = 1;
        sel = i;
      end
    end
    if (found) begin
      push_event((m_prev_valid && m_prev == sel) ? EV_CONTINUE : EV_STARTED, sel,
                 m_prio[sel], m_rem[sel]);
      m_prev = sel[3:0];
      m_prev_valid = 1;
      m_tick++;
      if (m_rem[sel] > 0) m_rem[sel]--;
      m_lastact[sel] = m_tick;
      if (m_rem[sel] == 0) begin
        m_status[sel] = ST_TERMINATED;
        m_prev_valid = 0;
        m_prev = 0;
        push_event(EV_FINISHED, sel, m_prio[sel], 0);
      end else begin
        m_qentry[sel] = m_tick;
        if (m_prio[sel] > 0) begin
          if (m_prio[sel] < PRIO_MAX) m_prio[sel]++;
          push_event(EV_DEMOTED, sel, m_prio[sel], m_rem[sel]);
        end
        m_status[sel] = ST_READY;
      end
    end else begin
      push_event(EV_IDLE, 0, 0, 0);
      m_tick++;
      m_prev_valid = 0;
      m_prev = 0;
    end
    mark_last();
  endfunction

  // send one item, with random hold-off before it
  task automatic send_item(logic c, logic [15:0] arr, logic [3:0] pr, logic [9:0] bu);
    while ($urandom_range(99) < send_gap_pct) @(posedge clk_i);
    start <= 1'b1;
    cmd_i <= c;
    arrival_time_i <= arr;
    priority_req_i <= pr;
    burst_i <= bu;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    schedule_item(c, arr, pr, bu);
    start <= 1'b0;
    cmd_i <= 1'($urandom_range(1));
    arrival_time_i <= 16'($urandom);
    // let the block see start low before the next item
    @(posedge clk_i);
  endtask

  task automatic load_task(logic [15:0] arr, logic [3:0] pr, logic [9:0] bu);
    send_item(CMD_LOAD, arr, pr, bu);
  endtask

  task automatic tick_n(int n);
    repeat (n) send_item(CMD_TICK, 16'($urandom), 4'($urandom), 10'($urandom));
  endtask

  // wait until all predictions are matched and the block is quiet
  task automatic drain();
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == REG_TIMEOUT) m_timeout = val;
    else m_floor = val[3:0];
  endtask

  // directed extremes: idle, done, zero burst, priority 0 and 15, fifo ties
  task automatic test_directed();
    tick_n(1);                          // all done on empty table
    load_task(16'd2, 4'd0, 10'd3);
    load_task(16'd0, 4'd15, 10'd2);
    load_task(16'd0, 4'd5, 10'd0);
    load_task(16'd1, 4'd5, 10'd1023);
    load_task(16'hFFFF, 4'd3, 10'd1);
    tick_n(12);
    write_reg(REG_TIMEOUT, 16'd1);
    tick_n(4);
    write_reg(REG_FLOOR, 16'd15);
    tick_n(3);
  endtask

  // random runs: a fresh scenario per phase is impossible without reset, so
  // interleave loads with ticks until the table fills; later loads are dropped
  task automatic test_random(int nitems, int gap);
    send_gap_pct = gap;
    for (int k = 0; k < nitems; k++) begin
      if (m_loaded < NTASK && $urandom_range(3) == 0)
        load_task(16'(m_tick + 16'($urandom_range(6))), 4'($urandom),
                  10'($urandom_range(1, 6)));
      else if ($urandom_range(40) == 0)
        load_task(16'($urandom), 4'($urandom), 10'($urandom));
      else
        tick_n(1);
    end
  endtask

  initial begin
    m_loaded = 0;
    m_tick = '0;
    m_prev = '0;
    m_prev_valid = 0;
    m_timeout = TIMEOUT_RESET;
    m_floor = FLOOR_RESET;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    write_reg(REG_TIMEOUT, 16'hFFFF);
    write_reg(REG_FLOOR, 16'd0);
    test_random(50, 0);
    write_reg(REG_TIMEOUT, 16'd6);
    write_reg(REG_FLOOR, 16'd7);
    test_random(50, 68);
    write_reg(REG_TIMEOUT, 16'd0);
    test_random(20, 37);
    write_reg(REG_TIMEOUT, 16'd30);
    write_reg(REG_FLOOR, 16'd3);
    test_random(70, 0);
    drain();
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
